>>> sv/crcfd_pkg.sv
// Shared types and constants for the CRC length-prefixed frame deframer.
package crcfd_pkg;

   // Parser phase codes; the two unused codes act as hunting.
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CRC_HI  = 3'd4,
      PH_CRC_LO  = 3'd5
   } phase_type;

   // Result kinds carried on rsp_tuser.
   typedef enum logic [2:0] {
      RK_BYTE    = 3'd0,
      RK_GOOD    = 3'd1,
      RK_BADCRC  = 3'd2,
      RK_BADLEN  = 3'd3,
      RK_TIMEOUT = 3'd4
   } kind_type;

   // Input kinds carried on req_tuser.
   localparam logic IN_BYTE = 1'b0;
   localparam logic IN_TICK = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] REG_START_BYTE    = 2'd0;
   localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd1;
   localparam logic [1:0] REG_FRAME_TIMEOUT = 2'd2;
   localparam logic [1:0] REG_CRC_SEED      = 2'd3;

   // Configuration reset values.
   localparam logic [7:0]  RST_START_BYTE    = 8'hAA;
   localparam logic [15:0] RST_MAX_PAYLOAD   = 16'd512;
   localparam logic [15:0] RST_FRAME_TIMEOUT = 16'd100;
   localparam logic [15:0] RST_CRC_SEED      = 16'hFFFF;

   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [15:0] WORD_MAX  = 16'hFFFF;

endpackage

>>> sv/crc_length_frame_deframer_unit.sv
// Top level of the CRC length-prefixed frame deframer.
// A result is registered and appears on rsp_* in the cycle after its request is accepted.
// Throughput: one request per cycle; the single result register sets the pace
// and a request is taken whenever that register is empty or being drained.
// Reset: synchronous, active high; clears the parser to hunting, the output
// register to empty and the configuration registers to their defaults.
module crc_length_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] kind
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] payload_byte, [23:8] frame_length
   output logic [2:0]  rsp_tuser,   // [2:0] result_kind
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // Configuration registers.
   logic [7:0]  start_byte_ff;
   logic [15:0] max_payload_ff;
   logic [15:0] frame_timeout_ff;
   logic [15:0] crc_seed_ff;

   // Parser state.
   crcfd_pkg::phase_type phase_ff, phase_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] idle_ff, idle_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   crcfd_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic [15:0]         rsp_len_ff, rsp_len_in;

   logic        req_take;
   logic [15:0] crc_step;
   logic [15:0] idle_sat;
   logic [15:0] count_sum;
   logic [15:0] len_full;
   logic        in_frame;

   // Take a request whenever the result register frees up this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;

   crcfd_crc16_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (req_tdata),
      .crc_next  (crc_step)
   );

   assign idle_sat  = (idle_ff == crcfd_pkg::WORD_MAX) ? idle_ff : idle_ff + 16'd1;
   assign count_sum = count_ff + 16'd1;
   assign len_full  = {len_ff[15:8], req_tdata};

   // Ticks count only while a frame is partly received.
   always_comb begin
      case (phase_ff)
         crcfd_pkg::PH_LEN_HI,
         crcfd_pkg::PH_LEN_LO,
         crcfd_pkg::PH_PAYLOAD,
         crcfd_pkg::PH_CRC_HI,
         crcfd_pkg::PH_CRC_LO: in_frame = 1'b1;
         default:              in_frame = 1'b0;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      crc_hi_in = crc_hi_ff;
      crc_in    = crc_ff;
      idle_in   = idle_ff;

      // Drop the held result once it is taken; hold it otherwise.
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_len_in   = rsp_len_ff;

      if (req_take) begin
         rsp_kind_in = crcfd_pkg::RK_BYTE;
         rsp_byte_in = 8'h00;
         rsp_len_in  = 16'h0000;
         if (req_tuser == crcfd_pkg::IN_TICK) begin
            if (in_frame) begin
               idle_in = idle_sat;
               // Abort the frame once idle time passes the limit.
               if (idle_sat > frame_timeout_ff) begin
                  phase_in     = crcfd_pkg::PH_HUNT;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = crcfd_pkg::RK_TIMEOUT;
                  rsp_len_in   = len_ff;
               end
            end
         end else begin
            idle_in = 16'h0000;
            case (phase_ff)
               crcfd_pkg::PH_LEN_HI: begin
                  len_in   = {req_tdata, 8'h00};
                  phase_in = crcfd_pkg::PH_LEN_LO;
               end
               crcfd_pkg::PH_LEN_LO: begin
                  len_in = len_full;
                  if (len_full == 16'h0000 || len_full > max_payload_ff) begin
                     phase_in     = crcfd_pkg::PH_HUNT;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = crcfd_pkg::RK_BADLEN;
                     rsp_len_in   = len_full;
                  end else begin
                     count_in = 16'h0000;
                     phase_in = crcfd_pkg::PH_PAYLOAD;
                  end
               end
               crcfd_pkg::PH_PAYLOAD: begin
                  // Pass the byte out and advance the running CRC.
                  crc_in       = crc_step;
                  count_in     = count_sum;
                  if (count_sum >= len_ff) begin
                     phase_in = crcfd_pkg::PH_CRC_HI;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = crcfd_pkg::RK_BYTE;
                  rsp_byte_in  = req_tdata;
               end
               crcfd_pkg::PH_CRC_HI: begin
                  crc_hi_in = req_tdata;
                  phase_in  = crcfd_pkg::PH_CRC_LO;
               end
               crcfd_pkg::PH_CRC_LO: begin
                  phase_in     = crcfd_pkg::PH_HUNT;
                  rsp_valid_in = 1'b1;
                  rsp_len_in   = len_ff;
                  if ({crc_hi_ff, req_tdata} == crc_ff) begin
                     rsp_kind_in = crcfd_pkg::RK_GOOD;
                  end else begin
                     rsp_kind_in = crcfd_pkg::RK_BADCRC;
                  end
               end
               default: begin
                  // Hunt for the start byte; unused codes land here too.
                  phase_in = crcfd_pkg::PH_HUNT;
                  if (req_tdata == start_byte_ff) begin
                     len_in   = 16'h0000;
                     count_in = 16'h0000;
                     crc_in   = crc_seed_ff;
                     phase_in = crcfd_pkg::PH_LEN_HI;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= crcfd_pkg::PH_HUNT;
         len_ff       <= 16'h0000;
         count_ff     <= 16'h0000;
         crc_hi_ff    <= 8'h00;
         crc_ff       <= crcfd_pkg::RST_CRC_SEED;
         idle_ff      <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         crc_hi_ff    <= crc_hi_in;
         crc_ff       <= crc_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload: no reset needed.
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_len_ff  <= rsp_len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff    <= crcfd_pkg::RST_START_BYTE;
         max_payload_ff   <= crcfd_pkg::RST_MAX_PAYLOAD;
         frame_timeout_ff <= crcfd_pkg::RST_FRAME_TIMEOUT;
         crc_seed_ff      <= crcfd_pkg::RST_CRC_SEED;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            crcfd_pkg::REG_START_BYTE:    start_byte_ff    <= csr_data[7:0];
            crcfd_pkg::REG_MAX_PAYLOAD:   max_payload_ff   <= csr_data;
            crcfd_pkg::REG_FRAME_TIMEOUT: frame_timeout_ff <= csr_data;
            crcfd_pkg::REG_CRC_SEED:      crc_seed_ff      <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

>>> sv/crcfd_crc16_byte.sv
// Byte-wide CRC-16-CCITT update, MSB first, no reflection.
module crcfd_crc16_byte (
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [15:0] crc_next
);

   always_comb begin
      logic [15:0] c;
      c = crc_cur ^ {data_byte, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ crcfd_pkg::CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_next = c;
   end

endmodule

>>> sv/crcfd_checker.sv
// Port-level checks for the CRC frame deframer, bound to its top level.
module crcfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index,
   input logic [15:0] csr_data
);

   logic req_take;
   logic rsp_stall;
   logic unused_ok;

   assign req_take  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign unused_ok = ^{req_tdata, req_tuser, csr_valid, csr_ready, csr_index, csr_data};

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No result appears without a request behind it.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !req_take && !rsp_stall |=> !rsp_tvalid)
      else $error("result without request");

   // Payload bytes carry no length.
   a_byte_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == crcfd_pkg::RK_BYTE |-> rsp_tdata[23:8] == 16'h0000)
      else $error("payload byte result with nonzero length");

   // Good and bad-CRC verdicts carry no byte and a nonzero length.
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == crcfd_pkg::RK_GOOD || rsp_tuser == crcfd_pkg::RK_BADCRC)
      |-> rsp_tdata[7:0] == 8'h00 && rsp_tdata[23:8] != 16'h0000)
      else $error("bad frame verdict fields");

endmodule

bind crc_length_frame_deframer_unit crcfd_checker u_crcfd_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for the CRC length-prefixed frame deframer.
module testbench;
   import crcfd_pkg::*;

   // Hard stop well beyond the slowest legal run.
   localparam int RUN_LIMIT = 2_000_000;
   localparam int MAX_REPORTS = 10;

   // One request on the input stream: a tick flag and a received byte.
   typedef struct packed {
      logic       tick;
      logic [7:0] data;
   } req_item_type;

   // One result as the deframer should present it.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  pbyte;
      logic [15:0] flen;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        req_tuser = IN_BYTE; // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [7:0] payload_byte, [23:8] frame_length
   logic [2:0]  rsp_tuser;           // [2:0] result_kind
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_START_BYTE;
   logic [15:0] csr_data = 16'h0000;

   crc_length_frame_deframer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to be offered, and results the deframer still owes us.
   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];

   // Idle percentages for each side; the hold flag comes from the pressure process.
   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   logic rsp_hold = 1'b0;
   int   phase_no = 0;

   // Bookkeeping for checks and the closing summary.
   logic req_fire = 1'b0;
   int   reqs_taken = 0;
   int   rsps_taken = 0;
   int   errors = 0;
   int   kind_seen[5] = '{default: 0};

   // Generator's copy of the configuration it last wrote.
   logic [7:0]  gen_start = RST_START_BYTE;
   logic [15:0] gen_max = RST_MAX_PAYLOAD;
   logic [15:0] gen_timeout = RST_FRAME_TIMEOUT;
   logic [15:0] gen_seed = RST_CRC_SEED;
   int          gen_count = 0;

   // Predictor state and configuration, updated at the accepting clock edge.
   logic [7:0]  m_start = RST_START_BYTE;
   logic [15:0] m_max = RST_MAX_PAYLOAD;
   logic [15:0] m_timeout = RST_FRAME_TIMEOUT;
   logic [15:0] m_seed = RST_CRC_SEED;
   phase_type   m_phase = PH_HUNT;
   logic [15:0] m_len = 16'h0000;
   logic [15:0] m_count = 16'h0000;
   logic [7:0]  m_crc_hi = 8'h00;
   logic [15:0] m_crc = RST_CRC_SEED;
   logic [15:0] m_idle = 16'h0000;

   // CRC-16-CCITT, one byte, MSB first.
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      int i;
      c = crc ^ {b, 8'h00};
      for (i = 0; i < 8; i++)
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   // Advance the deframer prediction by one accepted request.
   task automatic deframe_step(input logic tick, input logic [7:0] b);
      if (tick == IN_TICK) begin
         // Ticks only count while inside a frame.
         if (m_phase != PH_HUNT) begin
            if (m_idle != WORD_MAX)
               m_idle = m_idle + 16'd1;
            if (m_idle > m_timeout) begin
               m_phase = PH_HUNT;
               expected_rsps.push_back('{RK_TIMEOUT, 8'h00, m_len});
            end
         end
      end else begin
         m_idle = 16'h0000;
         case (m_phase)
            PH_LEN_HI: begin
               m_len = {b, 8'h00};
               m_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               m_len = {m_len[15:8], b};
               if (m_len == 16'h0000 || m_len > m_max) begin
                  m_phase = PH_HUNT;
                  expected_rsps.push_back('{RK_BADLEN, 8'h00, m_len});
               end else begin
                  m_count = 16'h0000;
                  m_phase = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               m_crc = crc16_step(m_crc, b);
               m_count = m_count + 16'd1;
               if (m_count >= m_len)
                  m_phase = PH_CRC_HI;
               expected_rsps.push_back('{RK_BYTE, b, 16'h0000});
            end
            PH_CRC_HI: begin
               m_crc_hi = b;
               m_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               m_phase = PH_HUNT;
               if ({m_crc_hi, b} == m_crc)
                  expected_rsps.push_back('{RK_GOOD, 8'h00, m_len});
               else
                  expected_rsps.push_back('{RK_BADCRC, 8'h00, m_len});
            end
            default: begin
               // Hunting: only the start byte opens a frame.
               m_phase = PH_HUNT;
               if (b == m_start) begin
                  m_len = 16'h0000;
                  m_count = 16'h0000;
                  m_crc = m_seed;
                  m_phase = PH_LEN_HI;
               end
            end
         endcase
      end
   endtask

   // Sender: hold a request until it is taken, then pick the next one or idle.
   always @(negedge clock) begin : send_proc
      req_item_type nxt;
      if (!req_tvalid || req_fire) begin
         if (!reset && pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            nxt = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.tick;
            req_tdata <= nxt.data;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall at random, and hold off completely while rsp_hold is set.
   always @(negedge clock)
      rsp_tready <= !reset && !rsp_hold && ($urandom_range(99) >= rx_idle_pct);

   // Monitor: check results against the oldest prediction, then predict new requests.
   always @(posedge clock) begin : watch_proc
      rsp_item_type want;
      req_fire <= req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsps_taken++;
            if (rsp_tuser < 3'd5)
               kind_seen[rsp_tuser]++;
            if (expected_rsps.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("unexpected result: kind %0d byte %02h length %04h",
                           rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8]);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tuser != want.kind || rsp_tdata[7:0] != want.pbyte ||
                   rsp_tdata[23:8] != want.flen) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display(
                        "mismatch %0d (exp/act): kind %0d/%0d byte %02h/%02h len %04h/%04h",
                        rsps_taken, want.kind, rsp_tuser, want.pbyte, rsp_tdata[7:0],
                        want.flen, rsp_tdata[23:8]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            reqs_taken++;
            deframe_step(req_tuser, req_tdata);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_START_BYTE:    m_start = csr_data[7:0];
               REG_MAX_PAYLOAD:   m_max = csr_data;
               REG_FRAME_TIMEOUT: m_timeout = csr_data;
               REG_CRC_SEED:      m_seed = csr_data;
               default: ;
            endcase
         end
      end
   end

   // Queue one request; counted ones make up the stimulus budget.
   task automatic queue_item(input logic tick, input logic [7:0] data, input bit counted);
      pending_reqs.push_back('{tick, data});
      if (counted)
         gen_count++;
   endtask

   // Queue a complete frame, optionally with a broken CRC and short tick pauses.
   task automatic queue_frame(input logic [15:0] len, input bit corrupt, input bit pauses);
      logic [15:0] crc;
      logic [7:0]  b;
      int i, j;
      crc = gen_seed;
      queue_item(IN_BYTE, gen_start, 1);
      queue_item(IN_BYTE, len[15:8], 1);
      queue_item(IN_BYTE, len[7:0], 1);
      for (i = 0; i < len; i++) begin
         b = 8'($urandom);
         if (pauses && $urandom_range(99) < 10)
            for (j = $urandom_range(3, 1); j > 0; j--)
               queue_item(IN_TICK, 8'($urandom), 1);
         queue_item(IN_BYTE, b, 1);
         crc = crc16_step(crc, b);
      end
      if (corrupt)
         crc = crc ^ (16'h0001 << $urandom_range(15, 0));
      queue_item(IN_BYTE, crc[15:8], 1);
      queue_item(IN_BYTE, crc[7:0], 1);
   endtask

   // Mostly well-formed frames with random content; the rest is bad lengths,
   // aborted frames, line noise and idle ticks.
   task automatic queue_traffic(input int n);
      int r, lim, k;
      logic [15:0] len;
      gen_count = 0;
      while (gen_count < n) begin
         r = $urandom_range(99);
         if (r < 68) begin
            lim = (gen_max < 12) ? gen_max : 12;
            if ($urandom_range(99) < 3)
               lim = (gen_max < 200) ? gen_max : 200;
            len = 16'($urandom_range(lim, 1));
            queue_frame(len, $urandom_range(99) < 25, 1);
         end else if (r < 78) begin
            // Zero or oversized length.
            if (gen_max == WORD_MAX || $urandom_range(1))
               len = 16'h0000;
            else
               len = 16'($urandom_range(32'hFFFF, gen_max + 1));
            queue_item(IN_BYTE, gen_start, 1);
            queue_item(IN_BYTE, len[15:8], 1);
            queue_item(IN_BYTE, len[7:0], 1);
         end else if (r < 83 && gen_timeout <= 40) begin
            // Start a frame and let it time out part way through the header.
            queue_item(IN_BYTE, gen_start, 1);
            if ($urandom_range(1))
               queue_item(IN_BYTE, 8'($urandom), 1);
            for (k = 0; k <= gen_timeout; k++)
               queue_item(IN_TICK, 8'($urandom), 1);
         end else if (r < 92) begin
            for (k = $urandom_range(4, 1); k > 0; k--)
               queue_item(IN_BYTE, 8'($urandom), 0);
         end else begin
            for (k = $urandom_range(5, 1); k > 0; k--)
               queue_item(IN_TICK, 8'($urandom), 0);
         end
      end
   endtask

   // Wait until every request is taken and every result has come back.
   task automatic drain;
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] sb, input logic [15:0] mx,
                             input logic [15:0] to, input logic [15:0] sd);
      write_reg(REG_START_BYTE, {8'h00, sb});
      write_reg(REG_MAX_PAYLOAD, mx);
      write_reg(REG_FRAME_TIMEOUT, to);
      write_reg(REG_CRC_SEED, sd);
      gen_start = sb;
      gen_max = mx;
      gen_timeout = to;
      gen_seed = sd;
   endtask

   // Main sequence: reset, then four configuration phases.
   initial begin : main_proc
      logic [15:0] crc;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: reset configuration, sender idles lightly, receiver heavily.
      tx_idle_pct = 37;
      rx_idle_pct = 70;
      phase_no = 1;
      crc = crc16_step(gen_seed, 8'h00);
      queue_item(IN_BYTE, 8'hAA, 1);          // one-byte frame, good CRC
      queue_item(IN_BYTE, 8'h00, 1);
      queue_item(IN_BYTE, 8'h01, 1);
      queue_item(IN_BYTE, 8'h00, 1);
      queue_item(IN_BYTE, crc[15:8], 1);
      queue_item(IN_BYTE, crc[7:0], 1);
      queue_frame(16'd2, 1, 0);               // bad CRC
      queue_item(IN_BYTE, 8'hAA, 1);          // zero length
      queue_item(IN_BYTE, 8'h00, 1);
      queue_item(IN_BYTE, 8'h00, 1);
      queue_item(IN_BYTE, 8'hAA, 1);          // length one above the limit
      queue_item(IN_BYTE, 8'h02, 1);
      queue_item(IN_BYTE, 8'h01, 1);
      queue_item(IN_TICK, 8'hFF, 1);          // tick while hunting
      queue_item(IN_BYTE, 8'h55, 1);          // non-start byte while hunting
      queue_traffic(250);
      drain();

      // Phase 2: low extremes, roles of the two sides swapped.
      set_config(8'h00, WORD_MAX, 16'd1, 16'h0000);
      tx_idle_pct = 70;
      rx_idle_pct = 37;
      phase_no = 2;
      queue_item(IN_BYTE, 8'h00, 1);          // timeout before any length byte
      queue_item(IN_TICK, 8'h00, 1);
      queue_item(IN_TICK, 8'h00, 1);
      queue_item(IN_BYTE, 8'h00, 1);          // timeout with half a length
      queue_item(IN_BYTE, 8'hFF, 1);
      queue_item(IN_TICK, 8'h00, 1);
      queue_item(IN_TICK, 8'h00, 1);
      queue_item(IN_BYTE, 8'h00, 1);          // bytes clear the idle count
      queue_item(IN_TICK, 8'h00, 1);
      queue_item(IN_BYTE, 8'h01, 1);
      queue_item(IN_TICK, 8'h00, 1);
      queue_item(IN_BYTE, 8'h05, 1);
      queue_item(IN_TICK, 8'h00, 1);
      queue_item(IN_TICK, 8'h00, 1);
      queue_item(IN_BYTE, 8'h00, 1);          // largest length, aborted in payload
      queue_item(IN_BYTE, 8'hFF, 1);
      queue_item(IN_BYTE, 8'hFF, 1);
      queue_item(IN_BYTE, 8'h12, 1);
      queue_item(IN_BYTE, 8'h34, 1);
      queue_item(IN_TICK, 8'h00, 1);
      queue_item(IN_TICK, 8'h00, 1);
      queue_traffic(250);
      drain();

      // Phase 3: high extremes; frames never time out, payload limit of one.
      set_config(8'hFF, 16'd1, WORD_MAX, 16'h1D0F);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      phase_no = 3;
      crc = crc16_step(gen_seed, 8'h5A);
      queue_item(IN_BYTE, 8'hFF, 1);
      repeat (6) queue_item(IN_TICK, 8'h00, 1);
      queue_item(IN_BYTE, 8'h00, 1);
      queue_item(IN_BYTE, 8'h01, 1);
      queue_item(IN_BYTE, 8'h5A, 1);
      queue_item(IN_BYTE, crc[15:8], 1);
      queue_item(IN_BYTE, crc[7:0], 1);
      queue_item(IN_BYTE, 8'hFF, 1);          // two bytes over a limit of one
      queue_item(IN_BYTE, 8'h00, 1);
      queue_item(IN_BYTE, 8'h02, 1);
      queue_traffic(100);
      drain();

      // Phase 4: a middle setting with a short timeout.
      set_config(8'($urandom), 16'd40, 16'd20, 16'($urandom));
      phase_no = 4;
      queue_traffic(180);
      drain();
      repeat (10) @(posedge clock);

      errors += expected_rsps.size();
      $display("Covered %0d requests and %0d results over four configurations.",
               reqs_taken, rsps_taken);
      $display("Results: %0d bytes, %0d good, %0d bad CRC, %0d bad length, %0d timeouts.",
               kind_seen[RK_BYTE], kind_seen[RK_GOOD], kind_seen[RK_BADCRC],
               kind_seen[RK_BADLEN], kind_seen[RK_TIMEOUT]);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Pressure: stall the receiver for long stretches while requests keep coming,
   // so the result register fills and the deframer stops taking input.
   initial begin : hold_proc
      int mark;
      wait (phase_no == 1);
      wait (reqs_taken >= 80);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (150) @(negedge clock);
      rsp_hold <= 1'b0;
      wait (phase_no == 4);
      mark = reqs_taken;
      wait (reqs_taken >= mark + 50);
      @(negedge clock);
      rsp_hold <= 1'b1;
      repeat (200) @(negedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : limit_proc
      #(RUN_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
sv/crcfd_pkg.sv
sv/crcfd_crc16_byte.sv
sv/crc_length_frame_deframer_unit.sv
sv/crcfd_checker.sv
test/testbench.sv
